// File: src/mbc3_pkg.sv
package mbc3_pkg;

   // cartridge geometry
   localparam int ROM_SEL_BITS   = 7;
   localparam int RAM_SEL_COUNT  = 4;
   localparam int RAM_SEL_BITS   = 2;
   localparam int MAP_BITS       = 21;
   localparam int ROM_PAGE_BITS  = 14;
   localparam int RAM_PAGE_BITS  = 13;

   // item commands
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // result targets
   localparam logic [2:0] TGT_NONE = 3'd0;
   localparam logic [2:0] TGT_ROM  = 3'd1;
   localparam logic [2:0] TGT_RAM  = 3'd2;
   localparam logic [2:0] TGT_RTC  = 3'd3;
   localparam logic [2:0] TGT_CTRL = 3'd4;

   // bus regions, address bits 15:13
   localparam logic [2:0] RGN_ENABLE  = 3'd0;
   localparam logic [2:0] RGN_ROMBANK = 3'd1;
   localparam logic [2:0] RGN_SELECT  = 3'd2;
   localparam logic [2:0] RGN_LATCH   = 3'd3;
   localparam logic [2:0] RGN_EXTRAM  = 3'd5;

   // data codes decoded on control writes
   localparam logic [3:0] RAM_KEY      = 4'hA;
   localparam logic [7:0] RAM_SEL_LAST = 8'd3;
   localparam logic [7:0] LATCH_ARM    = 8'h00;
   localparam logic [7:0] LATCH_FIRE   = 8'h01;

   // rtc register indexes
   localparam logic [2:0] RTC_SEC     = 3'd0;
   localparam logic [2:0] RTC_MIN     = 3'd1;
   localparam logic [2:0] RTC_HOUR    = 3'd2;
   localparam logic [2:0] RTC_DAY_LO  = 3'd3;
   localparam logic [2:0] RTC_DAY_HI  = 3'd4;
   localparam logic [7:0] RTC_SEL_LO  = 8'h08;
   localparam logic [7:0] RTC_SEL_HI  = 8'h0C;

   typedef struct packed {
      logic       tick;
      logic       reg_write;
      logic [2:0] index;
      logic [7:0] data;
      logic       latch_zero;
      logic       latch_one;
   } rtc_ctl_type;

endpackage

// File: src/mbc3_req_if.sv
interface mbc3_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink (input valid, command, address, write_data, output ready);
endinterface

// File: src/mbc3_rsp_if.sv
interface mbc3_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target;
   logic [20:0] mapped_address;
   logic [7:0]  read_data;

   modport source (output valid, target, mapped_address, read_data, input ready);
   modport sink (input valid, target, mapped_address, read_data, output ready);
endinterface

// File: src/mbc3_rtc.sv
module mbc3_rtc
   import mbc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rtc_ctl_type ctl,
   output logic [7:0]  rd_data
);

   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [4:0] hour_ff, hour_in;
   logic [8:0] day_ff, day_in;
   logic       ovf_ff, ovf_in;
   logic [7:0] hi_byte_ff, hi_byte_in;
   logic       halted_ff, halted_in;
   logic       armed_ff, armed_in;

   always_comb begin
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      day_in     = day_ff;
      ovf_in     = ovf_ff;
      hi_byte_in = hi_byte_ff;
      halted_in  = halted_ff;
      armed_in   = armed_ff;

      if (ctl.tick && !halted_ff) begin
         // cascade: out-of-range counts wrap at width without carry
         if (sec_ff == 6'd59) begin
            sec_in = '0;
            if (min_ff == 6'd59) begin
               min_in = '0;
               if (hour_ff == 5'd23) begin
                  hour_in = '0;
                  if (day_ff == 9'h1FF) begin
                     day_in = '0;
                     ovf_in = 1'b1;
                  end else begin
                     day_in = day_ff + 9'd1;
                  end
               end else begin
                  hour_in = hour_ff + 5'd1;
               end
            end else begin
               min_in = min_ff + 6'd1;
            end
         end else begin
            sec_in = sec_ff + 6'd1;
         end
      end

      if (ctl.reg_write) begin
         case (ctl.index)
            RTC_SEC:    sec_in  = ctl.data[5:0];
            RTC_MIN:    min_in  = ctl.data[5:0];
            RTC_HOUR:   hour_in = ctl.data[4:0];
            RTC_DAY_LO: day_in  = {day_ff[8], ctl.data};
            default: begin
               day_in     = {ctl.data[0], day_ff[7:0]};
               ovf_in     = ctl.data[7];
               hi_byte_in = ctl.data;
            end
         endcase
      end

      if (ctl.latch_zero) begin
         armed_in = 1'b1;
      end else if (ctl.latch_one) begin
         if (armed_ff) begin
            halted_in = !halted_ff;
         end
         armed_in = 1'b0;
      end
   end

   // read reflects state after this item's write
   always_comb begin
      case (ctl.index)
         RTC_SEC:    rd_data = {2'b00, sec_in};
         RTC_MIN:    rd_data = {2'b00, min_in};
         RTC_HOUR:   rd_data = {3'b000, hour_in};
         RTC_DAY_LO: rd_data = day_in[7:0];
         default:    rd_data = {ovf_in, halted_in, hi_byte_in[5:1], day_in[8]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff     <= '0;
         min_ff     <= '0;
         hour_ff    <= '0;
         day_ff     <= '0;
         ovf_ff     <= 1'b0;
         hi_byte_ff <= '0;
         halted_ff  <= 1'b1;
         armed_ff   <= 1'b0;
      end else begin
         sec_ff     <= sec_in;
         min_ff     <= min_in;
         hour_ff    <= hour_in;
         day_ff     <= day_in;
         ovf_ff     <= ovf_in;
         hi_byte_ff <= hi_byte_in;
         halted_ff  <= halted_in;
         armed_ff   <= armed_in;
      end
   end

   // a halted clock ignores ticks
   assert property (@(posedge clock) disable iff (reset)
      (ctl.tick && halted_ff && !ctl.reg_write) |=> $stable(sec_ff))
      else $error("rtc advanced while halted");

   // day overflow only sets through a wrap or a day-high write
   assert property (@(posedge clock) disable iff (reset)
      (!ovf_ff && !ctl.reg_write && !(ctl.tick && day_ff == 9'h1FF)) |=> !ovf_ff)
      else $error("day overflow set unexpectedly");

   // a write of one always disarms the halt toggle
   assert property (@(posedge clock) disable iff (reset)
      ctl.latch_one |=> !armed_ff)
      else $error("halt toggle still armed");

endmodule

// File: src/mbc3_bank_mapper_with_rtc.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | command, address, write_data
// rsp     | out | valid/ready | target, mapped_address, read_data
//
// one item per cycle while the rsp output is not stalled: decode and the rtc counter cascade are
// combinational, and the result lands in the rsp output register at the accept edge
// state (bank selects, enable, rtc counters) updates at that same edge
// req.ready is high while the output register is empty or being drained
// synchronous active-high reset: rom bank 1, clock halted, other state zero; rsp payload is not reset
module mbc3_bank_mapper_with_rtc
   import mbc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mbc3_req_if.sink    req,
   mbc3_rsp_if.source  rsp
);

   logic                     accept;
   logic                     is_wr, is_rd, is_tick;
   logic [2:0]               region;
   logic                     ext_hit;

   logic [ROM_SEL_BITS-1:0]  rom_sel_ff, rom_sel_in;
   logic [ROM_SEL_BITS-1:0]  rom_pick;
   logic [RAM_SEL_BITS-1:0]  ram_sel_ff, ram_sel_in;
   logic                     rtc_mode_ff, rtc_mode_in;
   logic [2:0]               rtc_index_ff, rtc_index_in;
   logic                     ram_en_ff, ram_en_in;

   rtc_ctl_type              rtc_ctl;
   logic [7:0]               rtc_rd;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               target_ff, target_in;
   logic [MAP_BITS-1:0]      mapped_ff, mapped_in;
   logic [7:0]               rdata_ff, rdata_in;
   logic [MAP_BITS-1:0]      ram_map, rom_map;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign is_wr   = accept && (req.command == CMD_WRITE);
   assign is_rd   = accept && (req.command == CMD_READ);
   assign is_tick = accept && (req.command == CMD_TICK);
   assign region  = req.address[15:13];
   // external ram window only answers while enabled
   assign ext_hit = (region == RGN_EXTRAM) && ram_en_ff;

   assign rom_pick = ROM_SEL_BITS'(req.write_data);

   assign ram_map = (MAP_BITS'(ram_sel_ff % RAM_SEL_COUNT) << RAM_PAGE_BITS)
                  + MAP_BITS'(req.address[RAM_PAGE_BITS-1:0]);
   assign rom_map = (MAP_BITS'(rom_sel_ff) << ROM_PAGE_BITS)
                  | MAP_BITS'(req.address[ROM_PAGE_BITS-1:0]);

   // control register writes
   always_comb begin
      rom_sel_in   = rom_sel_ff;
      ram_sel_in   = ram_sel_ff;
      rtc_mode_in  = rtc_mode_ff;
      rtc_index_in = rtc_index_ff;
      ram_en_in    = ram_en_ff;
      if (is_wr) begin
         case (region)
            RGN_ENABLE: ram_en_in = (req.write_data[3:0] == RAM_KEY);
            RGN_ROMBANK: begin
               // bank zero maps to bank one
               rom_sel_in = (rom_pick == '0) ? ROM_SEL_BITS'(1) : rom_pick;
            end
            RGN_SELECT: begin
               if (req.write_data <= RAM_SEL_LAST) begin
                  rtc_mode_in = 1'b0;
                  ram_sel_in  = RAM_SEL_BITS'(req.write_data);
               end else if (req.write_data inside {[RTC_SEL_LO:RTC_SEL_HI]}) begin
                  rtc_mode_in  = 1'b1;
                  rtc_index_in = 3'(req.write_data - RTC_SEL_LO);
               end
            end
            default: ;
         endcase
      end
   end

   // rtc controls for this item
   always_comb begin
      rtc_ctl.tick       = is_tick;
      rtc_ctl.reg_write  = is_wr && ext_hit && rtc_mode_ff;
      rtc_ctl.index      = rtc_index_ff;
      rtc_ctl.data       = req.write_data;
      rtc_ctl.latch_zero = is_wr && (region == RGN_LATCH) && (req.write_data == LATCH_ARM);
      rtc_ctl.latch_one  = is_wr && (region == RGN_LATCH) && (req.write_data == LATCH_FIRE);
   end

   mbc3_rtc u_rtc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rtc_ctl),
      .rd_data (rtc_rd)
   );

   // result for the accepted item
   always_comb begin
      target_in = TGT_NONE;
      mapped_in = '0;
      rdata_in  = '0;
      if (is_wr) begin
         if (region inside {RGN_ENABLE, RGN_ROMBANK, RGN_SELECT, RGN_LATCH}) begin
            target_in = TGT_CTRL;
         end else if (ext_hit) begin
            if (rtc_mode_ff) begin
               target_in = TGT_RTC;
               rdata_in  = rtc_rd;
            end else begin
               target_in = TGT_RAM;
               mapped_in = ram_map;
            end
         end
      end else if (is_rd) begin
         if (region inside {RGN_ENABLE, RGN_ROMBANK}) begin
            target_in = TGT_ROM;
            mapped_in = MAP_BITS'(req.address);
         end else if (region inside {RGN_SELECT, RGN_LATCH}) begin
            target_in = TGT_ROM;
            mapped_in = rom_map;
         end else if (ext_hit) begin
            if (rtc_mode_ff) begin
               target_in = TGT_RTC;
               rdata_in  = rtc_rd;
            end else begin
               target_in = TGT_RAM;
               mapped_in = ram_map;
            end
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_sel_ff   <= ROM_SEL_BITS'(1);
         ram_sel_ff   <= '0;
         rtc_mode_ff  <= 1'b0;
         rtc_index_ff <= RTC_SEC;
         ram_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rom_sel_ff   <= rom_sel_in;
         ram_sel_ff   <= ram_sel_in;
         rtc_mode_ff  <= rtc_mode_in;
         rtc_index_ff <= rtc_index_in;
         ram_en_ff    <= ram_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, loaded only on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= target_in;
         mapped_ff <= mapped_in;
         rdata_ff  <= rdata_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.target         = target_ff;
   assign rsp.mapped_address = mapped_ff;
   assign rsp.read_data      = rdata_ff;

   assert property (@(posedge clock) disable iff (reset) rom_sel_ff != '0)
      else $error("rom bank select reached zero");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req.command == CMD_TICK) |=> (rsp.valid && rsp.target == TGT_NONE))
      else $error("tick item gave a non-empty result");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> ((rsp.target != TGT_RAM && rsp.target != TGT_RTC) || $past(ram_en_ff)))
      else $error("external ram access while disabled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.target != TGT_RTC) |-> (rsp.read_data == 8'd0))
      else $error("read data set outside rtc access");

   assert property (@(posedge clock) disable iff (reset)
      rtc_index_ff <= RTC_DAY_HI)
      else $error("rtc index out of range");

endmodule
